FILE: src/sledpg_pkg.sv
// Shared types and constants for the status LED pattern generator.
// No dependencies.
`default_nettype none

package sledpg_pkg;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE   = 3'd0,
        ST_RECORD = 3'd1,
        ST_ADVERT = 3'd2,
        ST_XFER   = 3'd3,
        ST_ERROR  = 3'd4
    } status_t;

    typedef enum logic [MODE_W-1:0] {
        OVR_RUN       = 2'd0,
        OVR_FORCE_OFF = 2'd1,
        OVR_FORCE_ON  = 2'd2,
        OVR_RSVD      = 2'd3
    } override_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDLE_HALF   = 3'd0,
        CFG_ADV_HALF    = 3'd1,
        CFG_XFER_HALF   = 3'd2,
        CFG_ERR_FLASH   = 3'd3,
        CFG_ERR_PAUSE   = 3'd4,
        CFG_ERR_TOGGLES = 3'd5
    } cfg_idx_t;

    localparam logic [PERIOD_W-1:0] RST_IDLE_HALF   = 16'd500;
    localparam logic [PERIOD_W-1:0] RST_ADV_HALF    = 16'd250;
    localparam logic [PERIOD_W-1:0] RST_XFER_HALF   = 16'd100;
    localparam logic [PERIOD_W-1:0] RST_ERR_FLASH   = 16'd150;
    localparam logic [PERIOD_W-1:0] RST_ERR_PAUSE   = 16'd1000;
    localparam logic [COUNT_W-1:0]  RST_ERR_TOGGLES = 8'd6;

    localparam logic [PERIOD_W-1:0] ELAPSED_MAX = {PERIOD_W{1'b1}};

endpackage

`default_nettype wire

FILE: src/status_led_pattern_generator_core.sv
// Status LED pattern generator: one tick item in, one LED result item out.
// Depends on sledpg_pkg.
//
// channel   dir   handshake             payload
// s_        in    s_valid / s_ready     s_requested_status, s_override_mode
// m_        out   m_valid / m_ready     m_led_level, m_active_status, m_is_forced
// cfg_      in    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle unless a low m_ready stalls; result appears the cycle after
// acceptance, from the single pattern-update stage feeding the result register.
// s_ready is high while the result register is empty or being drained.
// cfg_ready is always high. Reset (aresetn low, synchronous) restores the
// register defaults and clears all pattern state.
`default_nettype none

module status_led_pattern_generator_core
    import sledpg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [STATUS_W-1:0]  s_requested_status,
    input  wire logic [MODE_W-1:0]    s_override_mode,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_led_level,
    output logic [STATUS_W-1:0]       m_active_status,
    output logic                      m_is_forced,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PERIOD_W-1:0]  cfg_data
);

    logic [PERIOD_W-1:0] idle_half_reg;
    logic [PERIOD_W-1:0] adv_half_reg;
    logic [PERIOD_W-1:0] xfer_half_reg;
    logic [PERIOD_W-1:0] err_flash_reg;
    logic [PERIOD_W-1:0] err_pause_reg;
    logic [COUNT_W-1:0]  err_toggles_reg;

    status_t             status_reg,  status_next;
    logic [PERIOD_W-1:0] elapsed_reg, elapsed_next;
    logic                phase_reg,   phase_next;
    logic                pin_reg,     pin_next;
    logic [COUNT_W-1:0]  flash_reg,   flash_next;
    logic                ovr_reg,     ovr_next;

    logic                m_valid_reg;
    logic                led_reg;
    logic [STATUS_W-1:0] act_status_reg;
    logic                forced_reg;

    logic                accept;
    logic                cfg_we;
    logic                req_valid;
    logic                cleared;
    logic [PERIOD_W-1:0] blink_period;
    logic [PERIOD_W-1:0] el_step;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    assign m_valid         = m_valid_reg;
    assign m_led_level     = led_reg;
    assign m_active_status = act_status_reg;
    assign m_is_forced     = forced_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_half_reg   <= RST_IDLE_HALF;
            adv_half_reg    <= RST_ADV_HALF;
            xfer_half_reg   <= RST_XFER_HALF;
            err_flash_reg   <= RST_ERR_FLASH;
            err_pause_reg   <= RST_ERR_PAUSE;
            err_toggles_reg <= RST_ERR_TOGGLES;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IDLE_HALF:   idle_half_reg   <= cfg_data;
                CFG_ADV_HALF:    adv_half_reg    <= cfg_data;
                CFG_XFER_HALF:   xfer_half_reg   <= cfg_data;
                CFG_ERR_FLASH:   err_flash_reg   <= cfg_data;
                CFG_ERR_PAUSE:   err_pause_reg   <= cfg_data;
                CFG_ERR_TOGGLES: err_toggles_reg <= cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // per-tick pattern update
    always_comb begin
        status_next  = status_reg;
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        pin_next     = pin_reg;
        flash_next   = flash_reg;
        ovr_next     = ovr_reg;
        cleared      = 1'b0;
        blink_period = idle_half_reg;
        el_step      = elapsed_reg;

        req_valid = (s_requested_status <= STATUS_W'(ST_ERROR));
        if (req_valid && (s_requested_status != STATUS_W'(status_reg))) begin
            status_next  = status_t'(s_requested_status);
            elapsed_next = '0;
            flash_next   = '0;
            cleared      = 1'b1;
            if (s_requested_status == STATUS_W'(ST_RECORD)) begin
                pin_next = 1'b1;
            end else if (s_requested_status == STATUS_W'(ST_IDLE)) begin
                phase_next = 1'b0;
            end
        end

        if ((s_override_mode == OVR_FORCE_OFF) || (s_override_mode == OVR_FORCE_ON)) begin
            ovr_next = 1'b1;
            pin_next = (s_override_mode == OVR_FORCE_ON);
        end else begin
            if (ovr_reg) begin
                ovr_next = 1'b0;
                cleared  = 1'b1;
            end
            el_step = cleared ? '0 : elapsed_next;
            if (!cleared && (el_step != ELAPSED_MAX)) begin
                el_step = el_step + 1'b1;
            end
            elapsed_next = el_step;

            case (status_next)
                ST_IDLE:   blink_period = idle_half_reg;
                ST_ADVERT: blink_period = adv_half_reg;
                ST_XFER:   blink_period = xfer_half_reg;
                default:   blink_period = idle_half_reg;
            endcase

            case (status_next)
                ST_RECORD: begin
                    pin_next = 1'b1;
                end
                ST_ERROR: begin
                    if (el_step >= err_flash_reg) begin
                        if (flash_next < err_toggles_reg) begin
                            phase_next   = !phase_next;
                            pin_next     = phase_next;
                            flash_next   = flash_next + 1'b1;
                            elapsed_next = '0;
                        end else begin
                            pin_next = 1'b0;
                            if (el_step >= err_pause_reg) begin
                                flash_next   = '0;
                                elapsed_next = '0;
                            end
                        end
                    end
                end
                default: begin
                    if (el_step >= blink_period) begin
                        phase_next   = !phase_next;
                        pin_next     = phase_next;
                        elapsed_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg  <= ST_IDLE;
            elapsed_reg <= '0;
            phase_reg   <= 1'b0;
            pin_reg     <= 1'b0;
            flash_reg   <= '0;
            ovr_reg     <= 1'b0;
        end else if (accept) begin
            status_reg  <= status_next;
            elapsed_reg <= elapsed_next;
            phase_reg   <= phase_next;
            pin_reg     <= pin_next;
            flash_reg   <= flash_next;
            ovr_reg     <= ovr_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            led_reg        <= pin_next;
            act_status_reg <= STATUS_W'(status_next);
            forced_reg     <= ovr_next;
        end
    end

    a_result_follows_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("result missing after accepted item");

    a_status_legal : assert property (@(posedge aclk) disable iff (!aresetn)
        status_reg <= ST_ERROR)
        else $error("status register out of range");

    a_force_on : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_override_mode == OVR_FORCE_ON)) |=> (m_led_level && m_is_forced))
        else $error("force on not reflected");

    a_force_off : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_override_mode == OVR_FORCE_OFF)) |=> (!m_led_level && m_is_forced))
        else $error("force off not reflected");

    a_record_high : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !ovr_next && (status_next == ST_RECORD)) |=> m_led_level)
        else $error("recording status must drive LED high");

endmodule

`default_nettype wire
